### src/qts_pkg.sv
// Shared types, byte codes and helpers for the quoted token splitter.
// Depends on nothing; every other file of the block but qts_if imports it.
package qts_pkg;

  localparam int unsigned QTS_FIFO_DEPTH = 2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_TOKEN   = 3'd1,
    MODE_ESCAPE  = 3'd2,
    MODE_QUOTE   = 3'd3,
    MODE_COMMENT = 3'd4,
    MODE_ESC_CR  = 3'd5
  } mode_e;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  // One queued action: a first result and an optional trailing end mark.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       second_end;
  } qts_entry_t;

  typedef struct packed {
    logic       valid;
    qts_entry_t entry;
  } qts_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qts_fifo_st_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

### src/qts_if.sv
// Valid/ready channel interfaces for the quoted token splitter.
// Standalone; carries input bytes in and token results out.
interface qts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface qts_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink (input valid, input out_kind, input out_byte, input out_last,
                output ready);
endinterface

### src/qts_front.sv
// Front end: accepts input bytes, tracks the tokenizer mode and queues actions.
// Depends on qts_pkg and qts_in_if.
module qts_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  qts_in_if.sink              in_i,
  input  qts_pkg::qts_fifo_st_t fifo_st_i,
  output qts_pkg::qts_push_t  push_o
);
  import qts_pkg::*;

  mode_e      mode_q, mode_d;
  logic       erm_q, erm_d;
  logic       qd_q, qd_d;
  logic       thb_q, thb_d;
  logic       ts_q, ts_d;

  mode_e      mode_eff;
  logic       done;
  logic       do_tok;
  logic       tok_ts;
  logic [7:0] b;
  logic       accept;

  assign in_i.ready = !fifo_st_i.full;
  assign accept     = in_i.valid && !fifo_st_i.full;
  assign b          = in_i.in_byte;

  always_comb begin
    mode_d = mode_q;
    erm_d  = erm_q;
    qd_d   = qd_q;
    thb_d  = thb_q;
    ts_d   = ts_q;
    push_o = '0;
    done   = 1'b0;
    do_tok = 1'b0;
    tok_ts = ts_q;
    mode_eff = mode_q;

    if (mode_q == MODE_ESC_CR) begin
      mode_eff = erm_q ? MODE_QUOTE : MODE_TOKEN;
      if (b == CH_LF) begin
        push_o.valid      = 1'b1;
        push_o.entry.kind = KIND_BYTE;
        push_o.entry.data = b;
        thb_d = 1'b1;
        done  = 1'b1;
      end
    end
    mode_d = mode_eff;

    if (!done) begin
      case (mode_eff)
        MODE_TOKEN: begin
          do_tok = 1'b1;
        end
        MODE_ESCAPE: begin
          push_o.valid      = 1'b1;
          push_o.entry.kind = KIND_BYTE;
          push_o.entry.data = b;
          thb_d  = 1'b1;
          mode_d = (b == CH_CR) ? MODE_ESC_CR : (erm_q ? MODE_QUOTE : MODE_TOKEN);
        end
        MODE_QUOTE: begin
          if (b == (qd_q ? CH_DQUOTE : CH_SQUOTE)) begin
            mode_d = MODE_TOKEN;
          end else if (b == CH_BSLASH) begin
            mode_d = MODE_ESCAPE;
            erm_d  = 1'b1;
          end else begin
            push_o.valid      = 1'b1;
            push_o.entry.kind = KIND_BYTE;
            push_o.entry.data = b;
            thb_d = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (b == CH_CR || b == CH_LF) begin
            mode_d = MODE_NORMAL;
          end
        end
        default: begin
          mode_d = MODE_NORMAL;
          if (!is_space(b)) begin
            do_tok = 1'b1;
            tok_ts = 1'b0;
          end
        end
      endcase
    end

    if (do_tok) begin
      if (b == CH_BSLASH) begin
        mode_d = MODE_ESCAPE;
        erm_d  = 1'b0;
        ts_d   = 1'b1;
      end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
        mode_d = MODE_QUOTE;
        qd_d   = (b == CH_DQUOTE);
        ts_d   = 1'b1;
      end else if (b == CH_HASH || b == CH_SEMI || is_space(b)) begin
        if (tok_ts) begin
          push_o.valid      = 1'b1;
          push_o.entry.kind = KIND_END;
          push_o.entry.data = '0;
          thb_d = 1'b0;
        end
        mode_d = is_space(b) ? MODE_NORMAL : MODE_COMMENT;
        ts_d   = 1'b0;
      end else begin
        push_o.valid      = 1'b1;
        push_o.entry.kind = KIND_BYTE;
        push_o.entry.data = b;
        thb_d  = 1'b1;
        mode_d = MODE_TOKEN;
        ts_d   = 1'b1;
      end
    end

    // flush a token that holds bytes, then drop all state
    if (in_i.in_last) begin
      if (thb_d) begin
        if (push_o.valid) begin
          push_o.entry.second_end = 1'b1;
        end else begin
          push_o.valid      = 1'b1;
          push_o.entry.kind = KIND_END;
          push_o.entry.data = '0;
        end
      end
      mode_d = MODE_NORMAL;
      erm_d  = 1'b0;
      qd_d   = 1'b0;
      thb_d  = 1'b0;
      ts_d   = 1'b0;
    end

    if (!accept) begin
      push_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      erm_q  <= 1'b0;
      qd_q   <= 1'b0;
      thb_q  <= 1'b0;
      ts_q   <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      erm_q  <= erm_d;
      qd_q   <= qd_d;
      thb_q  <= thb_d;
      ts_q   <= ts_d;
    end
  end

endmodule

### src/qts_fifo.sv
// Short action queue between the front and back ends.
// Depends on qts_pkg for the entry and status types.
module qts_fifo #(
  parameter int unsigned Depth = qts_pkg::QTS_FIFO_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qts_pkg::qts_push_t    push_i,
  input  logic                  pop_i,
  output qts_pkg::qts_entry_t   head_o,
  output qts_pkg::qts_fifo_st_t st_o
);
  import qts_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  qts_entry_t            storage_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign st_o.full  = (count_q == FullCnt);
  assign st_o.empty = (count_q == '0);
  assign do_push    = push_i.valid && !st_o.full;
  assign do_pop     = pop_i && !st_o.empty;
  assign head_o     = storage_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      storage_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

### src/qts_back.sv
// Back end: expands queued actions into results through one output register.
// Depends on qts_pkg and qts_out_if.
module qts_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qts_pkg::qts_entry_t   head_i,
  input  qts_pkg::qts_fifo_st_t fifo_st_i,
  output logic                  pop_o,
  qts_out_if.source             out_o
);
  import qts_pkg::*;

  logic       valid_q, valid_d;
  kind_e      kind_q, kind_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;
  logic       pend_q, pend_d;
  logic       load;

  assign out_o.valid    = valid_q;
  assign out_o.out_kind = kind_q;
  assign out_o.out_byte = data_q;
  assign out_o.out_last = last_q;

  assign load = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    kind_d  = kind_q;
    data_d  = data_q;
    last_d  = last_q;
    pend_d  = pend_q;
    pop_o   = 1'b0;
    if (load) begin
      if (pend_q) begin
        valid_d = 1'b1;
        kind_d  = KIND_END;
        data_d  = '0;
        last_d  = 1'b1;
        pend_d  = 1'b0;
      end else if (!fifo_st_i.empty) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        kind_d  = head_i.kind;
        data_d  = head_i.data;
        last_d  = !head_i.second_end;
        pend_d  = head_i.second_end;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
    last_q <= last_d;
  end

endmodule

### src/quoted_token_splitter_unit.sv
// Quoted token splitter: argument-string bytes in, token bytes out.
// Each result passes through the action queue and then the output register.
// Throughput: one byte per cycle while the queue has room; a byte that yields two
// results holds the single output register for both, and the queue absorbs that.
// Reset: asynchronous, active low; clears mode state, queue pointers, output valid.
module quoted_token_splitter_unit #(
  parameter int unsigned FifoDepth = qts_pkg::QTS_FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qts_in_if.sink     in_i,
  qts_out_if.source  out_o
);
  import qts_pkg::*;

  qts_push_t    push;
  qts_entry_t   head;
  qts_fifo_st_t fifo_st;
  logic         pop;

  qts_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .fifo_st_i (fifo_st),
    .push_o    (push)
  );

  qts_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .st_o   (fifo_st)
  );

  qts_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .fifo_st_i (fifo_st),
    .pop_o     (pop),
    .out_o     (out_o)
  );

`ifndef NO_ASSERTIONS
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.out_kind |-> out_o.out_byte == 8'h00)
    else $error("end mark carries a non-zero byte");

  a_second_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.out_last |=>
      out_o.valid && out_o.out_kind && out_o.out_last)
    else $error("trailing end mark missing after a non-final result");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_st.empty)
    else $error("queue popped while empty");
`endif

endmodule

### tb/tb_top.sv
// Self-checking bench for quoted_token_splitter_unit: byte requests in, token results out.
// Predicts the token stream from its own copy of the tokenizer state and checks each result.
// Depends on qts_pkg and the qts_in_if / qts_out_if interfaces.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qts_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } token_res_t;

  typedef logic [7:0] text_q_t[$];

  logic clk_i;
  logic rst_ni;

  qts_in_if  in_if ();
  qts_out_if out_if ();

  quoted_token_splitter_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // tokenizer state held by the predictor
  mode_e      rd_mode;
  logic       esc_to_quote;
  logic       dbl_quote;
  logic       tok_has_bytes;
  logic       tok_open;
  token_res_t step_res[2];
  int         step_n;

  token_res_t  token_stream_q[$];
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_cycles   = 0;
  int unsigned fail_count    = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen  = 0;
  int unsigned token_ends    = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
  endfunction

  function automatic mode_e escape_exit();
    if (esc_to_quote) return MODE_QUOTE;
    return MODE_TOKEN;
  endfunction

  task automatic clear_state();
    rd_mode       = MODE_NORMAL;
    esc_to_quote  = 1'b0;
    dbl_quote     = 1'b0;
    tok_has_bytes = 1'b0;
    tok_open      = 1'b0;
  endtask

  task automatic emit(input kind_e k, input logic [7:0] d);
    if (step_n < 2) begin
      step_res[step_n] = '{kind: k, data: d, last: 1'b0};
      step_n++;
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    emit(KIND_BYTE, b);
    tok_has_bytes = 1'b1;
  endtask

  task automatic close_token();
    emit(KIND_END, 8'h00);
    tok_has_bytes = 1'b0;
  endtask

  task automatic token_char(input logic [7:0] b);
    if (b == CH_BSLASH) begin
      rd_mode      = MODE_ESCAPE;
      esc_to_quote = 1'b0;
      tok_open     = 1'b1;
    end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
      rd_mode   = MODE_QUOTE;
      dbl_quote = (b == CH_DQUOTE);
      tok_open  = 1'b1;
    end else if (b == CH_HASH || b == CH_SEMI) begin
      if (tok_open) close_token();
      rd_mode  = MODE_COMMENT;
      tok_open = 1'b0;
    end else if (is_blank(b)) begin
      if (tok_open) close_token();
      rd_mode  = MODE_NORMAL;
      tok_open = 1'b0;
    end else begin
      add_byte(b);
      rd_mode  = MODE_TOKEN;
      tok_open = 1'b1;
    end
  endtask

  task automatic split_byte(input logic [7:0] b, input logic last);
    logic taken;
    taken  = 1'b0;
    step_n = 0;
    if (rd_mode == MODE_ESC_CR) begin
      rd_mode = escape_exit();
      if (b == CH_LF) begin
        add_byte(b);
        taken = 1'b1;
      end
    end
    if (!taken) begin
      case (rd_mode)
        MODE_TOKEN: token_char(b);
        MODE_ESCAPE: begin
          add_byte(b);
          if (b == CH_CR) rd_mode = MODE_ESC_CR;
          else rd_mode = escape_exit();
        end
        MODE_QUOTE: begin
          if (b == (dbl_quote ? CH_DQUOTE : CH_SQUOTE)) begin
            rd_mode = MODE_TOKEN;
          end else if (b == CH_BSLASH) begin
            rd_mode      = MODE_ESCAPE;
            esc_to_quote = 1'b1;
          end else begin
            add_byte(b);
          end
        end
        MODE_COMMENT: if (b == CH_CR || b == CH_LF) rd_mode = MODE_NORMAL;
        default: begin
          rd_mode = MODE_NORMAL;
          if (!is_blank(b)) begin
            tok_open = 1'b0;
            token_char(b);
          end
        end
      endcase
    end
    if (last) begin
      if (tok_has_bytes) close_token();
      clear_state();
    end
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) token_stream_q.push_back(step_res[i]);
  endtask

  // entered and left at a falling edge; valid stays high for a following request
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    split_byte(b, last);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input text_q_t text, input logic end_string);
    foreach (text[i]) send_byte(text[i], end_string && (i == text.size() - 1));
  endtask

  task automatic send_string(input int unsigned len);
    text_q_t     text;
    int unsigned r;
    while (text.size() < len) begin
      r = $urandom_range(99);
      if (r < 38) begin
        text.push_back(8'($urandom_range(8'h7A, 8'h30)));
      end else if (r < 52) begin
        case ($urandom_range(3))
          0: text.push_back(CH_SPACE);
          1: text.push_back(CH_TAB);
          2: text.push_back(CH_CR);
          default: text.push_back(CH_LF);
        endcase
      end else if (r < 60) begin
        text.push_back($urandom_range(1) ? CH_DQUOTE : CH_SQUOTE);
      end else if (r < 68) begin
        text.push_back(CH_BSLASH);
        if ($urandom_range(99) < 40) begin
          text.push_back(CH_CR);
          if ($urandom_range(99) < 60) text.push_back(CH_LF);
        end
      end else if (r < 74) begin
        text.push_back($urandom_range(1) ? CH_HASH : CH_SEMI);
      end else if (r < 80) begin
        text.push_back(CH_CR);
        text.push_back(CH_LF);
      end else begin
        text.push_back(8'($urandom_range(255)));
      end
    end
    send_text(text, 1'b1);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (token_stream_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_text('{8'h00, 8'hFF, CH_SPACE}, 1'b0);
    send_text('{CH_DQUOTE, CH_DQUOTE, CH_TAB}, 1'b0);
    send_text('{CH_HASH, 8'h78, CH_LF}, 1'b0);
    send_text('{8'h61, CH_SEMI, CH_CR}, 1'b0);
    send_text('{CH_BSLASH, CH_CR, CH_LF, 8'h62}, 1'b0);
    send_text('{CH_BSLASH, CH_CR, 8'h63}, 1'b0);
    send_text('{CH_SQUOTE, CH_SPACE, CH_BSLASH, CH_SQUOTE, CH_SQUOTE}, 1'b0);
    send_text('{8'h7A}, 1'b1);
    send_text('{CH_DQUOTE}, 1'b1);
  endtask

  task automatic test_random(input int unsigned src_pct, input int unsigned sink_pct,
                             input int unsigned count);
    int unsigned stop_at;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at       = requests_sent + count;
    while (requests_sent < stop_at) send_string($urandom_range(16, 1));
  endtask

  task automatic test_output_backpressure();
    int unsigned stop_at;
    src_idle_pct  = 0;
    sink_idle_pct = 10;
    hold_cycles   = 60;
    stop_at       = requests_sent + 50;
    while (requests_sent < stop_at) send_string($urandom_range(12, 4));
  endtask

  task automatic test_drain_pause();
    src_idle_pct  = 10;
    sink_idle_pct = 30;
    repeat (3) begin
      send_string($urandom_range(10, 3));
      wait_drained();
    end
  endtask

  // receiver: random stalls plus a counted hold-off when requested
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    token_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (out_if.out_kind == KIND_END) token_ends++;
      if (token_stream_q.size() == 0) begin
        $error("unpredicted result: out_kind %0d out_byte %02h out_last %0d",
               out_if.out_kind, out_if.out_byte, out_if.out_last);
        fail_count++;
      end else begin
        want = token_stream_q.pop_front();
        if (want.kind != out_if.out_kind) begin
          $error("out_kind: expected %0d, actual %0d", want.kind, out_if.out_kind);
          fail_count++;
        end
        if (want.data != out_if.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", want.data, out_if.out_byte);
          fail_count++;
        end
        if (want.last != out_if.out_last) begin
          $error("out_last: expected %0d, actual %0d", want.last, out_if.out_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_last = 1'b0;
    rst_ni        = 1'b0;
    clear_state();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(28, 47, 200);
    test_random(47, 28, 200);
    test_random(0, 0, 140);
    test_output_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("Sent %0d byte requests (directed, idling mixes, long hold-off, drain pauses)",
             requests_sent);
    $display("Checked %0d results, %0d of them token ends", results_seen, token_ends);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
